[hdl/mft_pkg.sv]
package mft_pkg;

  localparam int FUNC_W    = 3;
  localparam int MAC_W     = 48;
  localparam int ID_W      = 64;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;

  localparam logic [FUNC_W-1:0] FUNC_LEARN = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MOVE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_AGE   = 3'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [ID_W-1:0]  bridge;
    logic [ID_W-1:0]  port;
  } mft_entry_t;

  typedef struct packed {
    logic touch;
    logic remove;
  } mft_verdict_t;

endpackage

[hdl/mft_mem.sv]
module mft_mem
  import mft_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mft_entry_t               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mft_entry_t               rd_data
);

  mft_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/mft_match.sv]
module mft_match
  import mft_pkg::*;
(
  input  logic [FUNC_W-1:0] func,
  input  logic [MAC_W-1:0]  ev_mac,
  input  logic [ID_W-1:0]   ev_bridge,
  input  logic [ID_W-1:0]   ev_port,
  input  mft_entry_t        entry_in,
  output mft_verdict_t      verdict,
  output mft_entry_t        entry_out
);

  logic br_zero;
  logic pt_zero;
  logic br_eq;
  logic pt_eq;
  logic mac_eq;
  logic flush_hit;
  logic key_hit;

  assign br_zero = (ev_bridge == '0);
  assign pt_zero = (ev_port == '0);
  assign br_eq   = (ev_bridge == entry_in.bridge);
  assign pt_eq   = (ev_port == entry_in.port);
  assign mac_eq  = (ev_mac == entry_in.mac);

  assign flush_hit = (br_zero && pt_zero) || (pt_zero && br_eq) ||
                     (br_zero && pt_eq) || (br_eq && pt_eq);
  assign key_hit   = mac_eq && br_eq;

  always_comb begin
    verdict   = '0;
    entry_out = entry_in;
    case (func)
      FUNC_FLUSH: begin
        verdict.touch  = flush_hit;
        verdict.remove = flush_hit;
      end
      FUNC_MOVE: begin
        verdict.touch = key_hit;
        if (key_hit) begin
          entry_out.port = ev_port;
        end
      end
      FUNC_AGE: begin
        verdict.touch  = key_hit;
        verdict.remove = key_hit;
      end
      default: begin
        verdict = '0;
      end
    endcase
  end

endmodule

[hdl/mac_forwarding_table_events_top.sv]
// channel | ports                                              | beat taken when
// --------+----------------------------------------------------+-------------------
// event   | start, busy, in_func, in_mac_address, in_bridge_id, | start && !busy
//         | in_port_id                                          |
// result  | out_valid, out_status, out_touched_count           | out_valid (1 cycle)
//
// Learn and unknown events need no scan; the result shows the next cycle.
// Flush, move and age scan the live entries through the memory's read port,
// one entry per cycle, compacting survivors in place.
// Live entries sit packed in slots below the fill count; reset clears the count.
// No clearing pass after reset. The receiver cannot stall; busy holds events off.
module mac_forwarding_table_events_top
  import mft_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [MAC_W-1:0]    in_mac_address,
  input  logic [ID_W-1:0]     in_bridge_id,
  input  logic [ID_W-1:0]     in_port_id,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_touched_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [COUNT_W-1:0]  touched_r, touched_nxt;
  logic [FUNC_W-1:0]   ev_func_r, ev_func_nxt;
  logic [MAC_W-1:0]    ev_mac_r, ev_mac_nxt;
  logic [ID_W-1:0]     ev_bridge_r, ev_bridge_nxt;
  logic [ID_W-1:0]     ev_port_r, ev_port_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_touched_r, out_touched_nxt;

  logic               accept;
  logic               last;
  logic [COUNT_W-1:0] touched_sum;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  mft_entry_t         mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  mft_entry_t         mem_rd_data;
  mft_verdict_t       verdict;
  mft_entry_t         entry_upd;

  mft_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  mft_match u_match (
    .func      (ev_func_r),
    .ev_mac    (ev_mac_r),
    .ev_bridge (ev_bridge_r),
    .ev_port   (ev_port_r),
    .entry_in  (mem_rd_data),
    .verdict   (verdict),
    .entry_out (entry_upd)
  );

  assign busy              = (state_r == S_SCAN);
  assign accept            = start && !busy;
  assign last              = (rd_idx_r == cnt_r);
  assign touched_sum       = (verdict.touch && touched_r != COUNT_MAX) ?
                             touched_r + COUNT_W'(1) : touched_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_touched_count = out_touched_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    touched_nxt     = touched_r;
    ev_func_nxt     = ev_func_r;
    ev_mac_nxt      = ev_mac_r;
    ev_bridge_nxt   = ev_bridge_r;
    ev_port_nxt     = ev_port_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_touched_nxt = out_touched_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = '0;
    mem_wr_data     = '{mac: in_mac_address, bridge: in_bridge_id, port: in_port_id};
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ev_func_nxt   = in_func;
          ev_mac_nxt    = in_mac_address;
          ev_bridge_nxt = in_bridge_id;
          ev_port_nxt   = in_port_id;
          out_valid_nxt = 1'b1;
          case (in_func) inside
            FUNC_LEARN: begin
              if (cnt_r != CW'(TABLE_DEPTH)) begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = cnt_r[AW-1:0];
                cnt_nxt         = cnt_r + CW'(1);
                out_status_nxt  = STATUS_DONE;
                out_touched_nxt = COUNT_W'(1);
              end else begin
                out_status_nxt  = STATUS_FULL;
                out_touched_nxt = '0;
              end
            end
            FUNC_FLUSH, FUNC_MOVE, FUNC_AGE: begin
              out_status_nxt  = STATUS_DONE;
              out_touched_nxt = '0;
              if (cnt_r != '0) begin
                out_valid_nxt = 1'b0;
                mem_rd_en     = 1'b1;
                mem_rd_addr   = '0;
                rd_idx_nxt    = CW'(1);
                wr_idx_nxt    = '0;
                touched_nxt   = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              out_status_nxt  = STATUS_UNKNOWN;
              out_touched_nxt = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!last) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (!verdict.remove) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_idx_r[AW-1:0];
          mem_wr_data = entry_upd;
          wr_idx_nxt  = wr_idx_r + CW'(1);
        end
        touched_nxt = touched_sum;
        if (last) begin
          cnt_nxt         = wr_idx_nxt;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STATUS_DONE;
          out_touched_nxt = touched_sum;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    wr_idx_r      <= wr_idx_nxt;
    touched_r     <= touched_nxt;
    ev_func_r     <= ev_func_nxt;
    ev_mac_r      <= ev_mac_nxt;
    ev_bridge_r   <= ev_bridge_nxt;
    ev_port_r     <= ev_port_nxt;
    out_status_r  <= out_status_nxt;
    out_touched_r <= out_touched_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (wr_idx_r < rd_idx_r && rd_idx_r <= cnt_r))
    else $error("compaction write index overtook read index");

  a_full_no_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FULL) |-> (out_touched_r == '0))
    else $error("full status with nonzero count");

  a_grow_on_learn: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_func == FUNC_LEARN) |=> (cnt_r <= $past(cnt_r)))
    else $error("fill count grew without a learn");

  a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && last) |=> (out_valid_r && state_r == S_IDLE))
    else $error("scan finished without a result");

endmodule
